### hdl/pfba_pkg.sv
// Package for the page frame bitmap allocator: field widths, command and
// status codes, and parameter defaults. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pfba_pkg;

	localparam int NUM_FRAMES_DEF      = 4096;
	localparam int PAGE_BYTES_LOG2_DEF = 12;

	localparam int ADDR_W     = 24;
	localparam int KIND_W     = 2;
	localparam int STAT_W     = 3;
	localparam int RESV_W     = 13;
	localparam int WORD_BITS  = 64;
	localparam int WORD_SH    = 6;
	localparam int OUT_DATA_W = 32;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [KIND_W-1:0] kind_t;
	typedef logic [STAT_W-1:0] status_t;
	typedef logic [WORD_BITS-1:0] map_word_t;

	localparam kind_t KIND_ALLOC = 2'd0;
	localparam kind_t KIND_FREE  = 2'd1;
	localparam kind_t KIND_QUERY = 2'd2;
	localparam kind_t KIND_INIT  = 2'd3;

	localparam status_t STAT_OK            = 3'd0;
	localparam status_t STAT_MISALIGNED    = 3'd1;
	localparam status_t STAT_NOT_ALLOCATED = 3'd2;
	localparam status_t STAT_OUT_OF_FRAMES = 3'd3;
	localparam status_t STAT_OUT_OF_RANGE  = 3'd4;

endpackage
`default_nettype wire

### hdl/page_frame_bitmap_allocator.sv
// Top level of the first-fit page frame bitmap allocator.
// Depends on pfba_pkg and pfba_ram (the used-bit map, 64 frames per word).
//
// Channel  Direction  Handshake             Word contents (lowest bit up)
// s_       in         s_tvalid / s_tready   tdata: address[23:0]; tuser: kind[1:0]
// m_       out        m_tvalid / m_tready   tdata: status[2:0], frame_address[26:3],
//                                           used[27], zero[31:28]
// cfg_     in         cfg_valid / cfg_ready cfg_data: reserved_frames[12:0]
//
// Free and query read the frame's map word and test its bit (free clears a used
// bit); a rejected address goes straight to the result. Allocate reads one map
// word a cycle from word 0 up, over at most ceil(min(NUM_FRAMES,
// 2^(24-PAGE_BYTES_LOG2))/64) words; the single read port of the map sets that
// rate. Initialize writes every word, one a cycle.
// After reset the map is swept clear with s_tready low.
// One command is in flight at a time; a finished word waits in the output
// register while the next command is accepted and worked on.
`timescale 1ns / 1ps
`default_nettype none
module page_frame_bitmap_allocator #(
	parameter int NUM_FRAMES      = pfba_pkg::NUM_FRAMES_DEF,
	parameter int PAGE_BYTES_LOG2 = pfba_pkg::PAGE_BYTES_LOG2_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// command stream
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [pfba_pkg::ADDR_W-1:0]        s_tdata,  // address[23:0]
	input  wire logic [pfba_pkg::KIND_W-1:0]        s_tuser,  // kind[1:0]
	// result stream
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic      [pfba_pkg::OUT_DATA_W-1:0]    m_tdata,  // status[2:0],
	                                                          // frame_address[26:3],
	                                                          // used[27], zero[31:28]
	// reserved_frames register
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [pfba_pkg::RESV_W-1:0]        cfg_data
);

	// Map geometry
	localparam int MAP_WORDS = (NUM_FRAMES + pfba_pkg::WORD_BITS - 1) / pfba_pkg::WORD_BITS;
	localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int ADDRESSABLE = 1 << (pfba_pkg::ADDR_W - PAGE_BYTES_LOG2);
	// Allocate only hands out frames whose byte address fits the address field
	localparam int ALLOC_LIM = (NUM_FRAMES < ADDRESSABLE) ? NUM_FRAMES : ADDRESSABLE;
	localparam int LAST_SCAN = (ALLOC_LIM - 1) / pfba_pkg::WORD_BITS;
	localparam int LAST_BITS = ALLOC_LIM - LAST_SCAN * pfba_pkg::WORD_BITS;
	localparam pfba_pkg::map_word_t LAST_MASK =
		{pfba_pkg::WORD_BITS{1'b1}} >> (pfba_pkg::WORD_BITS - LAST_BITS);
	localparam logic [WA_W-1:0] LAST_SCAN_W = WA_W'(LAST_SCAN);
	localparam logic [WA_W-1:0] LAST_WORD_W = WA_W'(MAP_WORDS - 1);

	// Sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CLEAR = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_ACC   = 3'd3;
	localparam logic [2:0] S_CHK   = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0]                       state_q;
	logic [pfba_pkg::RESV_W-1:0]      resv_q;
	logic [pfba_pkg::RESV_W-1:0]      thr_q;
	logic [WA_W-1:0]                  sweep_q;
	logic                             resp_q;
	pfba_pkg::kind_t                  kind_q;
	pfba_pkg::addr_t                  fidx_q;
	logic [WA_W-1:0]                  ptr_q;
	logic                             issued_q;
	logic                             scan_v_s1;
	logic [WA_W-1:0]                  scan_w_s1;
	pfba_pkg::status_t                res_status_q;
	pfba_pkg::addr_t                  res_addr_q;
	logic                             res_used_q;
	logic                             m_tvalid_q;
	logic [pfba_pkg::OUT_DATA_W-1:0]  m_tdata_q;

	// Input decode
	pfba_pkg::addr_t                  in_fidx;
	logic                             in_misaligned;
	logic                             in_oor;

	// Memory ports
	logic                             wr_en;
	logic [WA_W-1:0]                  wr_addr;
	pfba_pkg::map_word_t              wr_data;
	logic [WA_W-1:0]                  rd_addr;
	pfba_pkg::map_word_t              rd_data;

	// Datapath
	pfba_pkg::map_word_t              init_word;
	pfba_pkg::map_word_t              free_bits;
	pfba_pkg::map_word_t              lowest;
	logic [pfba_pkg::WORD_SH-1:0]     low_pos;
	logic                             hit;
	logic [pfba_pkg::WORD_SH-1:0]     chk_bit;
	logic                             chk_used;
	logic [31:0]                      sweep_base;
	logic [31:0]                      thr_ext;
	logic [31:0]                      grant_addr;
	logic                             out_free;
	logic                             accept;

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign out_free  = !m_tvalid_q || m_tready;

	assign in_fidx       = s_tdata >> PAGE_BYTES_LOG2;
	assign in_misaligned = (s_tdata & pfba_pkg::ADDR_W'((1 << PAGE_BYTES_LOG2) - 1)) != '0;
	assign in_oor        = 32'(in_fidx) >= 32'(NUM_FRAMES);

	assign chk_bit  = fidx_q[pfba_pkg::WORD_SH-1:0];
	assign chk_used = rd_data[chk_bit];

	// Initialize pattern: bit i of the map is used while i is below the threshold
	always_comb begin
		sweep_base = 32'(sweep_q) << pfba_pkg::WORD_SH;
		thr_ext    = 32'(thr_q);
		if (thr_ext >= sweep_base + 32'(pfba_pkg::WORD_BITS)) begin
			init_word = '1;
		end else if (thr_ext <= sweep_base) begin
			init_word = '0;
		end else begin
			init_word = ~({pfba_pkg::WORD_BITS{1'b1}} <<
				pfba_pkg::WORD_SH'(thr_ext - sweep_base));
		end
	end

	// First free frame in the word under scan
	always_comb begin
		free_bits = ~rd_data & ((scan_w_s1 == LAST_SCAN_W) ? LAST_MASK : '1);
		lowest    = free_bits & (~free_bits + pfba_pkg::map_word_t'(1));
		hit       = |free_bits;
		low_pos   = '0;
		for (int i = 0; i < pfba_pkg::WORD_BITS; i++) begin
			if (lowest[i]) begin
				low_pos = low_pos | pfba_pkg::WORD_SH'(i);
			end
		end
		grant_addr = 32'({scan_w_s1, low_pos}) << PAGE_BYTES_LOG2;
	end

	// Memory port selection
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = sweep_q;
		wr_data = init_word;
		rd_addr = ptr_q;
		unique case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
			end
			S_SCAN: begin
				wr_en   = scan_v_s1 && hit;
				wr_addr = scan_w_s1;
				wr_data = rd_data | lowest;
			end
			S_ACC: begin
				rd_addr = WA_W'(fidx_q >> pfba_pkg::WORD_SH);
			end
			S_CHK: begin
				// free of a used frame: drop its bit
				wr_en   = (kind_q == pfba_pkg::KIND_FREE) && chk_used;
				wr_addr = WA_W'(fidx_q >> pfba_pkg::WORD_SH);
				wr_data = rd_data & ~(pfba_pkg::map_word_t'(1) << chk_bit);
			end
			S_IDLE, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	pfba_ram #(
		.WIDTH (pfba_pkg::WORD_BITS),
		.DEPTH (MAP_WORDS)
	) u_map (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resv_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			resv_q <= cfg_data;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			thr_q     <= '0;
			sweep_q   <= '0;
			resp_q    <= 1'b0;
			scan_v_s1 <= 1'b0;
			scan_w_s1 <= '0;
			issued_q  <= 1'b0;
			ptr_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						ptr_q     <= '0;
						issued_q  <= 1'b0;
						scan_v_s1 <= 1'b0;
						sweep_q   <= '0;
						unique case (s_tuser)
							pfba_pkg::KIND_ALLOC: state_q <= S_SCAN;
							pfba_pkg::KIND_INIT: begin
								thr_q   <= resv_q;
								resp_q  <= 1'b1;
								state_q <= S_CLEAR;
							end
							pfba_pkg::KIND_FREE, pfba_pkg::KIND_QUERY: begin
								state_q <= (in_misaligned || in_oor) ? S_DONE : S_ACC;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_CLEAR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == LAST_WORD_W) begin
						state_q <= resp_q ? S_DONE : S_IDLE;
					end
				end
				S_SCAN: begin
					// issue one read a cycle; judge the word that came back
					if (!issued_q) begin
						ptr_q <= ptr_q + 1'b1;
					end
					issued_q  <= issued_q || (ptr_q == LAST_SCAN_W);
					scan_w_s1 <= ptr_q;
					if (scan_v_s1 && (hit || scan_w_s1 == LAST_SCAN_W)) begin
						scan_v_s1 <= 1'b0;
						state_q   <= S_DONE;
					end else begin
						scan_v_s1 <= !issued_q;
					end
				end
				S_ACC: state_q <= S_CHK;
				S_CHK: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Command capture and result staging
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q       <= s_tuser;
			fidx_q       <= in_fidx;
			res_addr_q   <= '0;
			res_used_q   <= 1'b0;
			if (s_tuser == pfba_pkg::KIND_ALLOC || s_tuser == pfba_pkg::KIND_INIT) begin
				res_status_q <= pfba_pkg::STAT_OK;
			end else begin
				res_status_q <= in_misaligned ? pfba_pkg::STAT_MISALIGNED :
					in_oor ? pfba_pkg::STAT_OUT_OF_RANGE : pfba_pkg::STAT_OK;
			end
		end
		if (state_q == S_SCAN && scan_v_s1) begin
			if (hit) begin
				res_addr_q <= grant_addr[pfba_pkg::ADDR_W-1:0];
			end else if (scan_w_s1 == LAST_SCAN_W) begin
				res_status_q <= pfba_pkg::STAT_OUT_OF_FRAMES;
			end
		end
		if (state_q == S_CHK) begin
			if (kind_q == pfba_pkg::KIND_FREE) begin
				if (!chk_used) begin
					res_status_q <= pfba_pkg::STAT_NOT_ALLOCATED;
				end
			end else begin
				res_used_q <= chk_used;
			end
		end
	end

	// Output register: hold the word until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			m_tdata_q <= {4'd0, res_used_q, res_addr_q, res_status_q};
		end
	end

`ifndef ASSERT_OFF
	// no map write outside the sweep, scan and check steps
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_DONE || state_q == S_ACC) |-> !wr_en)
		else $error("map written while no command is working on it");

	// the scan never judges a word past the allocatable range
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && scan_v_s1) |-> (scan_w_s1 <= LAST_SCAN_W))
		else $error("scan ran past the last allocatable word");

	// a granted address is frame aligned
	a_grant_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && res_status_q == pfba_pkg::STAT_OK) |->
		((res_addr_q & pfba_pkg::ADDR_W'((1 << PAGE_BYTES_LOG2) - 1)) == '0))
		else $error("granted frame address not aligned");

	// one command at a time: accepting a word closes the input next cycle
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("second command accepted while one is in flight");
`endif

endmodule
`default_nettype wire

### hdl/pfba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pfba_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire
